/* rtl/core/lcdnw_pkg.sv */
// types, constants and microcode table for the character lcd nibble write sequencer
`timescale 1ns / 1ps
`default_nettype none

package lcdnw_pkg;

    // request operations
    localparam logic [1:0] OP_COMMAND = 2'd0;
    localparam logic [1:0] OP_DATA    = 2'd1;
    localparam logic [1:0] OP_INIT    = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_ENABLE_HIGH = 3'd0;
    localparam logic [2:0] REG_ENABLE_LOW  = 3'd1;
    localparam logic [2:0] REG_CMD_WAIT    = 3'd2;
    localparam logic [2:0] REG_POWER_UP    = 3'd3;
    localparam logic [2:0] REG_INIT_LONG   = 3'd4;
    localparam logic [2:0] REG_INIT_SHORT  = 3'd5;

    localparam int CFG_W    = 16;
    localparam int HOLD_W   = 20;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    // reset values
    localparam logic [CFG_W-1:0]  RST_ENABLE_HIGH = 16'd5;
    localparam logic [CFG_W-1:0]  RST_ENABLE_LOW  = 16'd50;
    localparam logic [CFG_W-1:0]  RST_CMD_WAIT    = 16'd2000;
    localparam logic [HOLD_W-1:0] RST_POWER_UP    = 20'd50000;
    localparam logic [CFG_W-1:0]  RST_INIT_LONG   = 16'd5000;
    localparam logic [CFG_W-1:0]  RST_INIT_SHORT  = 16'd150;

    // program layout
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] BYTE_START = 5'd0;
    localparam logic [STEP_W-1:0] INIT_START = 5'd4;
    localparam logic [STEP_W-1:0] PROG_LAST  = 5'd28;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] value;
    } t_in_item;

    typedef struct packed {
        logic              reg_select;
        logic              enable;
        logic [3:0]        bus_nibble;
        logic [HOLD_W-1:0] hold_us;
        logic              last;
    } t_out_item;

    typedef enum logic [1:0] {
        NIB_HIGH,
        NIB_LOW,
        NIB_CONST
    } t_nib_sel;

    typedef enum logic [1:0] {
        HOLD_ENABLE_HIGH,
        HOLD_ENABLE_LOW,
        HOLD_POWER_UP
    } t_hold_sel;

    typedef enum logic [1:0] {
        EXTRA_NONE,
        EXTRA_CMD,
        EXTRA_LONG,
        EXTRA_SHORT
    } t_extra_sel;

    typedef struct packed {
        logic       enable;
        t_nib_sel   nib_sel;
        logic [3:0] nib_const;
        t_hold_sel  hold_sel;
        t_extra_sel extra_sel;
        logic       last;
    } t_ucode;

    function automatic t_ucode mk_word(
        input logic       enable,
        input t_nib_sel   nib_sel,
        input logic [3:0] nib_const,
        input t_hold_sel  hold_sel,
        input t_extra_sel extra_sel,
        input logic       last
    );
        t_ucode w;
        w.enable    = enable;
        w.nib_sel   = nib_sel;
        w.nib_const = nib_const;
        w.hold_sel  = hold_sel;
        w.extra_sel = extra_sel;
        w.last      = last;
        return w;
    endfunction

    // E high half of a constant nibble
    function automatic t_ucode mk_pulse(input logic [3:0] nib);
        return mk_word(1'b1, NIB_CONST, nib, HOLD_ENABLE_HIGH, EXTRA_NONE, 1'b0);
    endfunction

    // E low half of a constant nibble
    function automatic t_ucode mk_settle(input logic [3:0] nib, input t_extra_sel extra,
                                         input logic last);
        return mk_word(1'b0, NIB_CONST, nib, HOLD_ENABLE_LOW, extra, last);
    endfunction

    // control store: byte write at BYTE_START, init run at INIT_START
    function automatic t_ucode ucode_rom(input logic [STEP_W-1:0] addr);
        t_ucode w;
        case (addr)
            5'd0:  w = mk_word(1'b1, NIB_HIGH, 4'h0, HOLD_ENABLE_HIGH, EXTRA_NONE, 1'b0);
            5'd1:  w = mk_word(1'b0, NIB_HIGH, 4'h0, HOLD_ENABLE_LOW, EXTRA_NONE, 1'b0);
            5'd2:  w = mk_word(1'b1, NIB_LOW, 4'h0, HOLD_ENABLE_HIGH, EXTRA_NONE, 1'b0);
            5'd3:  w = mk_word(1'b0, NIB_LOW, 4'h0, HOLD_ENABLE_LOW, EXTRA_CMD, 1'b1);
            5'd4:  w = mk_word(1'b0, NIB_CONST, 4'h0, HOLD_POWER_UP, EXTRA_NONE, 1'b0);
            5'd5:  w = mk_pulse(4'h3);
            5'd6:  w = mk_settle(4'h3, EXTRA_LONG, 1'b0);
            5'd7:  w = mk_pulse(4'h3);
            5'd8:  w = mk_settle(4'h3, EXTRA_SHORT, 1'b0);
            5'd9:  w = mk_pulse(4'h3);
            5'd10: w = mk_settle(4'h3, EXTRA_NONE, 1'b0);
            5'd11: w = mk_pulse(4'h2);
            5'd12: w = mk_settle(4'h2, EXTRA_NONE, 1'b0);
            5'd13: w = mk_pulse(4'h2);
            5'd14: w = mk_settle(4'h2, EXTRA_NONE, 1'b0);
            5'd15: w = mk_pulse(4'h8);
            5'd16: w = mk_settle(4'h8, EXTRA_CMD, 1'b0);
            5'd17: w = mk_pulse(4'h0);
            5'd18: w = mk_settle(4'h0, EXTRA_NONE, 1'b0);
            5'd19: w = mk_pulse(4'hC);
            5'd20: w = mk_settle(4'hC, EXTRA_CMD, 1'b0);
            5'd21: w = mk_pulse(4'h0);
            5'd22: w = mk_settle(4'h0, EXTRA_NONE, 1'b0);
            5'd23: w = mk_pulse(4'h6);
            5'd24: w = mk_settle(4'h6, EXTRA_CMD, 1'b0);
            5'd25: w = mk_pulse(4'h0);
            5'd26: w = mk_settle(4'h0, EXTRA_NONE, 1'b0);
            5'd27: w = mk_pulse(4'h1);
            5'd28: w = mk_settle(4'h1, EXTRA_CMD, 1'b1);
            default: w = mk_word(1'b0, NIB_CONST, 4'h0, HOLD_ENABLE_LOW, EXTRA_NONE, 1'b1);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/char_lcd_nibble_write_sequencer.sv */
// top level of the character lcd nibble write sequencer
`timescale 1ns / 1ps
`default_nettype none

// Turns each request (command byte, data byte or power-on init) into a run of
// timed pin events for a 4-bit character lcd: rs, e, d7..d4 and a hold time in
// microseconds, with last marking the final event of the run. A byte request
// gives four events (high nibble then low nibble, each e high then e low) and
// the init request gives 25 events. The pace is one microcode step per cycle:
// a step counter walks a 29-word control store and each word produces one
// event into the output register, so output stall stretches a run cycle for
// cycle. A new request is taken in the cycle that the final event of the
// previous run is issued. Operation code 3 is accepted and produces no events.
// The six timing registers sit on an apb port at byte addresses 4*index; write
// them only while no run is active.
module char_lcd_nibble_write_sequencer (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    // request channel
    input  wire                           i_in_valid,
    output logic                          o_in_stall,
    input  lcdnw_pkg::t_in_item           i_in_data,
    // pin event channel
    output logic                          o_out_valid,
    input  wire                           i_out_stall,
    output lcdnw_pkg::t_out_item          o_out_data,
    // configuration port
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire [lcdnw_pkg::ADDR_W-1:0]   paddr,
    input  wire [lcdnw_pkg::DATA_W-1:0]   pwdata,
    output logic [lcdnw_pkg::DATA_W-1:0]  prdata,
    output logic                          pready
);

    // timing registers
    logic [lcdnw_pkg::CFG_W-1:0]  r_enable_high;
    logic [lcdnw_pkg::CFG_W-1:0]  r_enable_low;
    logic [lcdnw_pkg::CFG_W-1:0]  r_cmd_wait;
    logic [lcdnw_pkg::HOLD_W-1:0] r_power_up;
    logic [lcdnw_pkg::CFG_W-1:0]  r_init_long;
    logic [lcdnw_pkg::CFG_W-1:0]  r_init_short;

    // sequencer state
    logic                         r_busy;
    logic [lcdnw_pkg::STEP_W-1:0] r_step;
    logic                         r_rs;
    logic [7:0]                   r_value;

    // output register
    logic                 r_out_valid;
    lcdnw_pkg::t_out_item r_out;

    logic                         cfg_write;
    logic [2:0]                   cfg_index;
    logic                         in_accept;
    logic                         issue;
    lcdnw_pkg::t_ucode            word;
    lcdnw_pkg::t_out_item         n_out;
    logic [lcdnw_pkg::HOLD_W-1:0] hold_base;
    logic [lcdnw_pkg::CFG_W-1:0]  hold_extra;
    logic [lcdnw_pkg::STEP_W-1:0] n_step;

    // ---------------------------------------------------------------------
    // apb register file
    // ---------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_index = paddr[4:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable_high <= lcdnw_pkg::RST_ENABLE_HIGH;
            r_enable_low  <= lcdnw_pkg::RST_ENABLE_LOW;
            r_cmd_wait    <= lcdnw_pkg::RST_CMD_WAIT;
            r_power_up    <= lcdnw_pkg::RST_POWER_UP;
            r_init_long   <= lcdnw_pkg::RST_INIT_LONG;
            r_init_short  <= lcdnw_pkg::RST_INIT_SHORT;
        end else if (cfg_write) begin
            unique case (cfg_index)
                lcdnw_pkg::REG_ENABLE_HIGH: r_enable_high <= pwdata[lcdnw_pkg::CFG_W-1:0];
                lcdnw_pkg::REG_ENABLE_LOW:  r_enable_low  <= pwdata[lcdnw_pkg::CFG_W-1:0];
                lcdnw_pkg::REG_CMD_WAIT:    r_cmd_wait    <= pwdata[lcdnw_pkg::CFG_W-1:0];
                lcdnw_pkg::REG_POWER_UP:    r_power_up    <= pwdata[lcdnw_pkg::HOLD_W-1:0];
                lcdnw_pkg::REG_INIT_LONG:   r_init_long   <= pwdata[lcdnw_pkg::CFG_W-1:0];
                lcdnw_pkg::REG_INIT_SHORT:  r_init_short  <= pwdata[lcdnw_pkg::CFG_W-1:0];
                default: ; // unmapped addresses ignore writes
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            lcdnw_pkg::REG_ENABLE_HIGH: prdata = {16'd0, r_enable_high};
            lcdnw_pkg::REG_ENABLE_LOW:  prdata = {16'd0, r_enable_low};
            lcdnw_pkg::REG_CMD_WAIT:    prdata = {16'd0, r_cmd_wait};
            lcdnw_pkg::REG_POWER_UP:    prdata = {12'd0, r_power_up};
            lcdnw_pkg::REG_INIT_LONG:   prdata = {16'd0, r_init_long};
            lcdnw_pkg::REG_INIT_SHORT:  prdata = {16'd0, r_init_short};
            default:                    prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // microcode fetch and event datapath
    // ---------------------------------------------------------------------
    assign word = lcdnw_pkg::ucode_rom(r_step);

    // a step issues whenever the output register is free or being emptied
    assign issue = r_busy && (!r_out_valid || !i_out_stall);

    // next request may come in alongside the final event of the current run
    assign o_in_stall = r_busy && !(issue && word.last);
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        unique case (word.hold_sel)
            lcdnw_pkg::HOLD_ENABLE_HIGH: hold_base = {4'd0, r_enable_high};
            lcdnw_pkg::HOLD_ENABLE_LOW:  hold_base = {4'd0, r_enable_low};
            lcdnw_pkg::HOLD_POWER_UP:    hold_base = r_power_up;
            default:                     hold_base = {4'd0, r_enable_low};
        endcase
    end

    always_comb begin
        unique case (word.extra_sel)
            lcdnw_pkg::EXTRA_NONE:  hold_extra = '0;
            // command wait applies only to rs low runs
            lcdnw_pkg::EXTRA_CMD:   hold_extra = r_rs ? '0 : r_cmd_wait;
            lcdnw_pkg::EXTRA_LONG:  hold_extra = r_init_long;
            lcdnw_pkg::EXTRA_SHORT: hold_extra = r_init_short;
            default:                hold_extra = '0;
        endcase
    end

    always_comb begin
        n_out.reg_select = r_rs;
        n_out.enable     = word.enable;
        unique case (word.nib_sel)
            lcdnw_pkg::NIB_HIGH:  n_out.bus_nibble = r_value[7:4];
            lcdnw_pkg::NIB_LOW:   n_out.bus_nibble = r_value[3:0];
            lcdnw_pkg::NIB_CONST: n_out.bus_nibble = word.nib_const;
            default:              n_out.bus_nibble = word.nib_const;
        endcase
        // low plus extra stays below 2^17, no overflow out of 20 bits
        n_out.hold_us = hold_base + {4'd0, hold_extra};
        n_out.last    = word.last;
    end

    assign n_step = r_step + 1'b1;

    // step counter and request latch
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= lcdnw_pkg::BYTE_START;
        end else if (in_accept) begin
            r_busy <= (i_in_data.operation == lcdnw_pkg::OP_COMMAND) ||
                      (i_in_data.operation == lcdnw_pkg::OP_DATA) ||
                      (i_in_data.operation == lcdnw_pkg::OP_INIT);
            r_step <= (i_in_data.operation == lcdnw_pkg::OP_INIT) ?
                      lcdnw_pkg::INIT_START : lcdnw_pkg::BYTE_START;
        end else if (issue) begin
            if (word.last) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= n_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rs    <= (i_in_data.operation == lcdnw_pkg::OP_DATA);
            r_value <= i_in_data.value;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (issue) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // step counter never runs past the end of the program
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_step <= lcdnw_pkg::PROG_LAST))
        else $error("step counter beyond program end");

    // a valid request starts a run
    a_run_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && ((i_in_data.operation == lcdnw_pkg::OP_COMMAND) ||
                       (i_in_data.operation == lcdnw_pkg::OP_DATA) ||
                       (i_in_data.operation == lcdnw_pkg::OP_INIT))) |=> r_busy)
        else $error("accepted request did not start a run");

    // final step ends the run unless a new request comes in
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && word.last && !in_accept) |=> !r_busy)
        else $error("run did not end after final step");

    // an issued event always reaches the output register
    a_issue_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |=> (o_out_valid && (o_out_data.last == $past(word.last))))
        else $error("issued event missing from output");
`endif

endmodule

`default_nettype wire
